@@ hw/rtl/gfmc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gfmc_pkg
// Shared constants, codes and handshake structs for the gesture flight mode
// controller.
// ----------------------------------------------------------------------------
package gfmc_pkg;

    localparam int DEFAULT_COUNTER_BITS = 16;
    localparam int DEFAULT_TILT_BITS    = 16;

    // tilt divider widths: quotient never exceeds the stick span
    localparam int DEN_W = 15;
    localparam int QUO_W = 9;
    localparam int NUM_W = DEN_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    localparam logic [QUO_W-1:0] STICK_SPAN = QUO_W'(400);

    localparam logic [10:0] PWM_MIN  = 11'd1100;
    localparam logic [10:0] PWM_MAX  = 11'd1900;
    localparam logic [10:0] PWM_MID  = 11'd1500;
    localparam logic [10:0] PWM_BOTH = 11'd1250;

    localparam logic [2:0] MODE_INIT  = 3'd0;
    localparam logic [2:0] MODE_LAND  = 3'd1;
    localparam logic [2:0] MODE_ARM   = 3'd2;
    localparam logic [2:0] MODE_SAFE  = 3'd3;
    localparam logic [2:0] MODE_FLY   = 3'd4;
    localparam logic [2:0] MODE_HOLD  = 3'd5;
    localparam logic [2:0] MODE_AWAIT = 3'd6;

    localparam logic [2:0] LED_OFF    = 3'd0;
    localparam logic [2:0] LED_GREEN  = 3'd1;
    localparam logic [2:0] LED_YELLOW = 3'd2;
    localparam logic [2:0] LED_RED    = 3'd3;
    localparam logic [2:0] LED_BLUE   = 3'd4;

    localparam logic [1:0] BLINK_STEADY = 2'd0;
    localparam logic [1:0] BLINK_SLOW   = 2'd1;
    localparam logic [1:0] BLINK_NORMAL = 2'd2;
    localparam logic [1:0] BLINK_FAST   = 2'd3;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_TIME    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_TIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISARM_TIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIMB       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 3'd6;

    localparam logic [15:0] RST_ARM_TIME    = 16'd300;
    localparam logic [15:0] RST_SAFE_TIME   = 16'd100;
    localparam logic [15:0] RST_DISARM_TIME = 16'd300;
    localparam logic [15:0] RST_HOLD_TIME   = 16'd200;
    localparam logic [15:0] RST_CLIMB       = 16'd5;
    localparam logic [14:0] RST_DEAD_BAND   = 15'd100;
    localparam logic [14:0] RST_FULL_SCALE  = 15'd500;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic div_start;
        logic update;
        logic out_load;
    } gfmc_cmd_t;

    typedef struct packed {
        logic div_done;
    } gfmc_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/gesture_flight_mode_controller.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gesture_flight_mode_controller
// Glove gesture driven flight mode controller producing RC pulse widths.
//
// Input channel s_*: one beat per control pass (tick, gesture flags, buttons,
// hand tilt x/y). Result channel m_*: one beat per pass with throttle, arm,
// pitch and roll widths, LED colour/blink and the flight mode.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready, write
// only while no pass is in flight; index 7 is ignored.
// A pass steps through latch, prep, divider start, a wait on the
// one-bit-per-cycle tilt dividers (nine steps plus the done check, two lanes
// in parallel), state update and load.
// The result register frees the input side: a new beat is taken while the
// previous result waits; a pass that finishes against a stalled receiver
// holds in its last step until the result register drains.
// Reset (aresetn low, synchronous): mode init, counters and held pulse widths
// cleared, configuration back to its default values, no result pending.
// ----------------------------------------------------------------------------
module gesture_flight_mode_controller #(
    parameter int COUNTER_BITS = gfmc_pkg::DEFAULT_COUNTER_BITS,
    parameter int TILT_BITS    = gfmc_pkg::DEFAULT_TILT_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [gfmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                    cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_tick,
    input  wire logic                           s_glove_inverted,
    input  wire logic                           s_glove_fist,
    input  wire logic                           s_glove_up,
    input  wire logic                           s_glove_down,
    input  wire logic                           s_button_disarm,
    input  wire logic                           s_button_hold,
    input  wire logic signed [TILT_BITS-1:0]    s_hand_tilt_x,
    input  wire logic signed [TILT_BITS-1:0]    s_hand_tilt_y,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [10:0]                         m_throttle_us,
    output logic [10:0]                         m_arm_us,
    output logic [10:0]                         m_pitch_us,
    output logic [10:0]                         m_roll_us,
    output logic [2:0]                          m_led_colour,
    output logic [1:0]                          m_led_blink,
    output logic [2:0]                          m_flight_mode
);
    import gfmc_pkg::*;

    gfmc_cmd_t cmd;
    gfmc_sts_t sts;

    assign cfg_ready = 1'b1;

    gfmc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    gfmc_datapath #(
        .COUNTER_BITS (COUNTER_BITS),
        .TILT_BITS    (TILT_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_tick           (s_tick),
        .s_glove_inverted (s_glove_inverted),
        .s_glove_fist     (s_glove_fist),
        .s_glove_up       (s_glove_up),
        .s_glove_down     (s_glove_down),
        .s_button_disarm  (s_button_disarm),
        .s_button_hold    (s_button_hold),
        .s_hand_tilt_x    (s_hand_tilt_x),
        .s_hand_tilt_y    (s_hand_tilt_y),
        .m_throttle_us    (m_throttle_us),
        .m_arm_us         (m_arm_us),
        .m_pitch_us       (m_pitch_us),
        .m_roll_us        (m_roll_us),
        .m_led_colour     (m_led_colour),
        .m_led_blink      (m_led_blink),
        .m_flight_mode    (m_flight_mode)
    );

endmodule
`default_nettype wire

@@ hw/rtl/gfmc_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gfmc_div
// Restoring divider, one quotient bit per cycle, for the tilt stick scaling.
// ----------------------------------------------------------------------------
module gfmc_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [gfmc_pkg::NUM_W-1:0] num,
    input  wire logic [gfmc_pkg::DEN_W-1:0] den,
    output logic                           done,
    output logic [gfmc_pkg::QUO_W-1:0]     quo,
    output logic                           rem_nz
);
    import gfmc_pkg::*;

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             fits;

    assign fits = (rem_reg >= dsh_reg);

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = num;
            dsh_next  = NUM_W'(den) << (QUO_W - 1);
            cnt_next  = CNT_W'(QUO_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? rem_reg - dsh_reg : rem_reg;
            quo_next  = {quo_reg[QUO_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done   = !busy_reg;
    assign quo    = quo_reg;
    assign rem_nz = (rem_reg != '0);

endmodule
`default_nettype wire

@@ hw/rtl/gfmc_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gfmc_datapath
// Configuration registers, mode state, tilt stick lanes and result register.
// ----------------------------------------------------------------------------
module gfmc_datapath #(
    parameter int COUNTER_BITS = gfmc_pkg::DEFAULT_COUNTER_BITS,
    parameter int TILT_BITS    = gfmc_pkg::DEFAULT_TILT_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire gfmc_pkg::gfmc_cmd_t           cmd,
    output gfmc_pkg::gfmc_sts_t                sts,
    input  wire logic                          cfg_we,
    input  wire logic [gfmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data,
    input  wire logic                          s_tick,
    input  wire logic                          s_glove_inverted,
    input  wire logic                          s_glove_fist,
    input  wire logic                          s_glove_up,
    input  wire logic                          s_glove_down,
    input  wire logic                          s_button_disarm,
    input  wire logic                          s_button_hold,
    input  wire logic signed [TILT_BITS-1:0]   s_hand_tilt_x,
    input  wire logic signed [TILT_BITS-1:0]   s_hand_tilt_y,
    output logic [10:0]                        m_throttle_us,
    output logic [10:0]                        m_arm_us,
    output logic [10:0]                        m_pitch_us,
    output logic [10:0]                        m_roll_us,
    output logic [2:0]                         m_led_colour,
    output logic [1:0]                         m_led_blink,
    output logic [2:0]                         m_flight_mode
);
    import gfmc_pkg::*;

    localparam int MAG_W = (TILT_BITS > DEN_W) ? TILT_BITS : DEN_W;
    localparam int CMP_W = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    function automatic logic timed_out(input logic [COUNTER_BITS-1:0] el,
                                       input logic [15:0] lim);
        return CMP_W'(el) > CMP_W'(lim);
    endfunction

    function automatic logic [10:0] stick(input logic sat, input logic dz,
                                          input logic neg, input logic invert,
                                          input logic [QUO_W-1:0] q,
                                          input logic rnz);
        logic [10:0] res;
        if (sat) begin
            res = neg ? PWM_MIN : PWM_MAX;
        end else if (dz) begin
            res = PWM_MID;
        end else if (neg == invert) begin
            res = PWM_MID + 11'(q);
        end else begin
            res = PWM_MID - 11'(q) - 11'(rnz);
        end
        return res;
    endfunction

    // configuration
    logic [15:0] arm_time_reg, safe_time_reg, disarm_time_reg, hold_time_reg;
    logic [15:0] climb_reg;
    logic [14:0] dead_reg, full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_time_reg    <= RST_ARM_TIME;
            safe_time_reg   <= RST_SAFE_TIME;
            disarm_time_reg <= RST_DISARM_TIME;
            hold_time_reg   <= RST_HOLD_TIME;
            climb_reg       <= RST_CLIMB;
            dead_reg        <= RST_DEAD_BAND;
            full_reg        <= RST_FULL_SCALE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ARM_TIME:    arm_time_reg    <= cfg_data;
                REG_SAFE_TIME:   safe_time_reg   <= cfg_data;
                REG_DISARM_TIME: disarm_time_reg <= cfg_data;
                REG_HOLD_TIME:   hold_time_reg   <= cfg_data;
                REG_CLIMB:       climb_reg       <= cfg_data;
                REG_DEAD_BAND:   dead_reg        <= cfg_data[14:0];
                REG_FULL_SCALE:  full_reg        <= cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // input beat
    logic tick_reg, inv_reg, fist_reg, up_reg, down_reg, bdis_reg, bhold_reg;
    logic [TILT_BITS-1:0] tilt_reg [2];

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            tick_reg    <= s_tick;
            inv_reg     <= s_glove_inverted;
            fist_reg    <= s_glove_fist;
            up_reg      <= s_glove_up;
            down_reg    <= s_glove_down;
            bdis_reg    <= s_button_disarm;
            bhold_reg   <= s_button_hold;
            tilt_reg[0] <= s_hand_tilt_x;
            tilt_reg[1] <= s_hand_tilt_y;
        end
    end

    // stick lanes: 0 = x (roll), 1 = y (pitch)
    logic [DEN_W-1:0] den_reg;
    logic             sat_reg [2];
    logic             dz_reg  [2];
    logic             neg_reg [2];
    logic [NUM_W-1:0] num_reg [2];
    logic [QUO_W-1:0] quo     [2];
    logic             rnz     [2];
    logic             ldone   [2];

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            den_reg <= full_reg - dead_reg;
        end
    end

    for (genvar i = 0; i < 2; i++) begin : g_lane
        logic                 neg;
        logic [TILT_BITS-1:0] mag;
        logic [MAG_W-1:0]     mag_ext;
        logic [DEN_W-1:0]     diff;

        assign neg     = tilt_reg[i][TILT_BITS-1];
        assign mag     = neg ? (~tilt_reg[i] + TILT_BITS'(1)) : tilt_reg[i];
        assign mag_ext = MAG_W'(mag);
        assign diff    = DEN_W'(mag_ext - MAG_W'(dead_reg));

        always_ff @(posedge aclk) begin
            if (cmd.prep) begin
                neg_reg[i] <= neg;
                sat_reg[i] <= (mag_ext > MAG_W'(full_reg));
                dz_reg[i]  <= (mag_ext <= MAG_W'(dead_reg));
                num_reg[i] <= NUM_W'(diff) * NUM_W'(STICK_SPAN);
            end
        end

        gfmc_div u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (cmd.div_start),
            .num     (num_reg[i]),
            .den     (den_reg),
            .done    (ldone[i]),
            .quo     (quo[i]),
            .rem_nz  (rnz[i])
        );
    end

    assign sts.div_done = ldone[0] && ldone[1];

    // mode state
    logic [2:0]              mode_reg, mode_next;
    logic [2:0]              target_reg, target_next;
    logic [COUNTER_BITS-1:0] elapsed_reg, elapsed_next, el_tick;
    logic [10:0]             thr_reg, thr_next, arm_reg, arm_next;
    logic [10:0]             pitch_reg, pitch_next, roll_reg, roll_next;
    logic [2:0]              colour_reg, colour_next;
    logic [1:0]              blink_reg, blink_next;
    logic                    both_btn;

    assign el_tick  = (tick_reg && elapsed_reg != CNT_MAX) ?
                      elapsed_reg + COUNTER_BITS'(1) : elapsed_reg;
    assign both_btn = bdis_reg && bhold_reg;

    always_comb begin
        mode_next    = mode_reg;
        target_next  = target_reg;
        elapsed_next = elapsed_reg;
        thr_next     = thr_reg;
        arm_next     = arm_reg;
        pitch_next   = pitch_reg;
        roll_next    = roll_reg;
        colour_next  = colour_reg;
        blink_next   = blink_reg;
        if (cmd.update) begin
            if (mode_reg == MODE_AWAIT) begin
                if (!bhold_reg) begin
                    mode_next = target_reg;
                end
            end else begin
                elapsed_next = el_tick;
                unique case (mode_reg)
                    MODE_LAND: begin
                        colour_next = LED_GREEN;
                        thr_next    = PWM_MIN;
                        arm_next    = PWM_MIN;
                        if (inv_reg && fist_reg) begin
                            if (timed_out(el_tick, arm_time_reg)) begin
                                mode_next = MODE_ARM;
                            end
                            blink_next = BLINK_FAST;
                        end else begin
                            elapsed_next = '0;
                            blink_next   = BLINK_STEADY;
                        end
                    end
                    MODE_ARM: begin
                        colour_next = LED_YELLOW;
                        blink_next  = BLINK_NORMAL;
                        thr_next    = PWM_MIN;
                        arm_next    = PWM_MAX;
                        if (!inv_reg && fist_reg) begin
                            if (timed_out(el_tick, safe_time_reg)) begin
                                mode_next = MODE_SAFE;
                            end
                        end else begin
                            elapsed_next = '0;
                        end
                    end
                    MODE_SAFE: begin
                        if (!fist_reg) begin
                            mode_next = MODE_FLY;
                        end else begin
                            pitch_next = PWM_MID;
                            roll_next  = PWM_MID;
                            priority if (bdis_reg) begin
                                if (timed_out(el_tick, disarm_time_reg)) begin
                                    mode_next = MODE_LAND;
                                end
                                colour_next = LED_GREEN;
                                blink_next  = BLINK_FAST;
                            end else if (bhold_reg) begin
                                if (timed_out(el_tick, hold_time_reg)) begin
                                    mode_next   = MODE_AWAIT;
                                    target_next = MODE_HOLD;
                                end
                                colour_next = LED_BLUE;
                                blink_next  = BLINK_FAST;
                            end else if (up_reg && thr_reg < PWM_MAX) begin
                                if (timed_out(el_tick, climb_reg)) begin
                                    thr_next     = thr_reg + 11'd1;
                                    elapsed_next = '0;
                                end
                                colour_next = LED_RED;
                                blink_next  = BLINK_NORMAL;
                            end else if (down_reg && thr_reg > PWM_MIN) begin
                                if (timed_out(el_tick, climb_reg)) begin
                                    thr_next     = thr_reg - 11'd1;
                                    elapsed_next = '0;
                                end
                                colour_next = LED_RED;
                                blink_next  = BLINK_NORMAL;
                            end else begin
                                elapsed_next = '0;
                                colour_next  = LED_RED;
                                blink_next   = BLINK_SLOW;
                            end
                        end
                    end
                    MODE_FLY: begin
                        if (fist_reg) begin
                            mode_next = MODE_SAFE;
                        end else begin
                            colour_next = LED_RED;
                            blink_next  = BLINK_FAST;
                            pitch_next  = stick(sat_reg[1], dz_reg[1], neg_reg[1], 1'b0,
                                                quo[1], rnz[1]);
                            roll_next   = stick(sat_reg[0], dz_reg[0], neg_reg[0], 1'b1,
                                                quo[0], rnz[0]);
                        end
                    end
                    MODE_HOLD: begin
                        colour_next = LED_BLUE;
                        blink_next  = BLINK_SLOW;
                        pitch_next  = PWM_MID;
                        roll_next   = PWM_MID;
                        if (bhold_reg) begin
                            if (timed_out(el_tick, hold_time_reg)) begin
                                mode_next   = MODE_AWAIT;
                                target_next = MODE_SAFE;
                            end
                            colour_next = LED_RED;
                            blink_next  = BLINK_FAST;
                        end else begin
                            elapsed_next = '0;
                        end
                    end
                    default: begin
                        thr_next   = PWM_MIN;
                        arm_next   = PWM_MIN;
                        pitch_next = PWM_MID;
                        roll_next  = PWM_MID;
                        mode_next  = MODE_LAND;
                    end
                endcase
                if ((mode_next == MODE_SAFE || mode_next == MODE_FLY ||
                     mode_next == MODE_HOLD) && both_btn) begin
                    elapsed_next = '0;
                    thr_next     = PWM_BOTH;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_INIT;
            target_reg  <= MODE_INIT;
            elapsed_reg <= '0;
            thr_reg     <= '0;
            arm_reg     <= '0;
            pitch_reg   <= '0;
            roll_reg    <= '0;
            colour_reg  <= LED_OFF;
            blink_reg   <= BLINK_STEADY;
        end else begin
            mode_reg    <= mode_next;
            target_reg  <= target_next;
            elapsed_reg <= elapsed_next;
            thr_reg     <= thr_next;
            arm_reg     <= arm_next;
            pitch_reg   <= pitch_next;
            roll_reg    <= roll_next;
            colour_reg  <= colour_next;
            blink_reg   <= blink_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_throttle_us <= thr_reg;
            m_arm_us      <= arm_reg;
            m_pitch_us    <= pitch_reg;
            m_roll_us     <= roll_reg;
            m_led_colour  <= colour_reg;
            m_led_blink   <= blink_reg;
            m_flight_mode <= mode_reg;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/gfmc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gfmc_ctrl
// Sequencer for one control pass and the result channel valid flag.
// ----------------------------------------------------------------------------
module gfmc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output gfmc_pkg::gfmc_cmd_t      cmd,
    input  wire gfmc_pkg::gfmc_sts_t sts
);
    import gfmc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DWAIT  = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready       = (state_reg == S_IDLE);
    assign cmd.load_in   = s_valid && s_ready;
    assign cmd.prep      = (state_reg == S_PREP);
    assign cmd.div_start = (state_reg == S_DSTART);
    assign cmd.update    = (state_reg == S_UPDATE);
    assign cmd.out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (cmd.load_in) state_next = S_PREP;
            S_PREP:   state_next = S_DSTART;
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:  if (sts.div_done) state_next = S_UPDATE;
            S_UPDATE: state_next = S_OUT;
            S_OUT:    if (cmd.out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_div_ready_at_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPDATE) |-> sts.div_done)
        else $error("state update with divider still busy");

    a_div_goes_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !sts.div_done)
        else $error("divider did not start");

    a_out_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("result beat not presented after load");
`endif

endmodule
`default_nettype wire
